// ===== rtl/sorted_page_tracking_table_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted page tracking table assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PAGE_TRACKING_TABLE_MACROS_SVH
`define SORTED_PAGE_TRACKING_TABLE_MACROS_SVH

// property that must hold at every edge out of reset
`define SPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must be followed by a consequence in the next cycle
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted page tracking table package
// Transaction types, operation and status codes, cell link and fsm states.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;

  // operation codes
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // input transaction
  typedef struct packed {
    func_t             func;
    logic [KEY_W-1:0]  virt_addr;
    logic [DATA_W-1:0] entry_data;
  } in_t;

  // result transaction
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  entry_count;
  } out_t;

  // what one cell hands to its upper neighbor
  typedef struct packed {
    logic              gt;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } link_t;

  // control sequence states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT,
    ST_ENCODE
  } state_t;

endpackage

// ===== rtl/sorted_page_tracking_table.sv =====
// ----------------------------------------------------------------------------
// Sorted page tracking table
// Sequence: accept, compare, commit of the cell shift, slot encode into the
//   result register; busy from acceptance until the slot encode ends, so a
//   new item is taken only when the block is idle.
// Every cell compares and shifts in parallel, so the time does not depend on
//   the fill level or on TABLE_DEPTH.
// Reset: synchronous, active low; table becomes empty, no result pending.
// ----------------------------------------------------------------------------
`include "sorted_page_tracking_table_macros.svh"

module sorted_page_tracking_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spt_pkg::in_t  in_item,
  output logic          out_valid,
  output spt_pkg::out_t out_item
);
  import spt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  state_t               state_r, state_nxt;
  in_t                  cmd_r;
  logic [CW-1:0]        count_r;
  status_t              status_r;
  logic [TABLE_DEPTH-1:0] place_r;
  logic                 out_valid_r;
  out_t                 out_r;

  logic                 cmp_en;
  logic                 wr_en;
  logic                 full;
  logic                 dup;
  logic                 accept;
  link_t                link [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [TABLE_DEPTH-1:0] ins_vec;
  logic [IW-1:0]        slot_idx;
  logic [IW+SLOT_W-1:0] slot_ext;
  logic [CW+CNT_W-1:0]  cnt_ext;

  assign accept = start && !busy;
  assign full   = (count_r == CW'(TABLE_DEPTH));
  assign dup    = |eq_vec;

  // row of cells, lowest address at index zero
  assign link[0] = '0;
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    spt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmp_en (cmp_en),
      .wr_en  (wr_en),
      .cnt    (count_r),
      .addr   (cmd_r.virt_addr),
      .data   (cmd_r.entry_data),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .eq_o   (eq_vec[i]),
      .ins_o  (ins_vec[i])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and cell controls
  always_comb begin
    state_nxt = state_r;
    cmp_en    = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmp_en    = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        wr_en     = (cmd_r.func == FUNC_INSERT) && !full && !dup;
        state_nxt = ST_ENCODE;
      end
      ST_ENCODE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // command capture
  always_ff @(posedge clk) begin
    if (accept) cmd_r <= in_item;
  end

  // fill count, status and marked slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      status_r <= STATUS_OK;
      place_r  <= '0;
    end else if (state_r == ST_COMMIT) begin
      if (cmd_r.func == FUNC_CLEAR) begin
        count_r  <= '0;
        status_r <= STATUS_OK;
        place_r  <= '0;
      end else if (full) begin
        status_r <= STATUS_FULL;
        place_r  <= '0;
      end else if (dup) begin
        status_r <= STATUS_DUP;
        place_r  <= eq_vec;
      end else begin
        count_r  <= count_r + CW'(1);
        status_r <= STATUS_OK;
        place_r  <= ins_vec;
      end
    end
  end

  // one-hot slot mark to index
  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (place_r[i]) slot_idx = slot_idx | IW'(i);
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};
  assign cnt_ext  = {{CNT_W{1'b0}}, count_r};

  // result register, strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_ENCODE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ENCODE) begin
      out_r.status      <= status_r;
      out_r.slot        <= slot_ext[SLOT_W-1:0];
      out_r.entry_count <= cnt_ext[CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  `SPT_ASSERT(a_count_range, count_r <= CW'(TABLE_DEPTH), "fill count above table depth")
  `SPT_ASSERT(a_place_onehot, $onehot0(place_r), "more than one slot marked")
  `SPT_ASSERT_NEXT(a_accept_eval, accept, state_r == ST_EVAL, "accepted item not evaluated")
  `SPT_ASSERT_NEXT(a_encode_out, state_r == ST_ENCODE, out_valid_r, "result strobe missing")
  `SPT_ASSERT_NEXT(a_reject_hold,
                   state_r == ST_COMMIT && !wr_en && cmd_r.func == FUNC_INSERT,
                   count_r == $past(count_r), "rejected insert changed fill count")

endmodule

// ===== rtl/spt_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted page tracking table cell
// Holds one entry, compares it with the broadcast key and shifts it upward.
// ----------------------------------------------------------------------------
module spt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmp_en,
  input  logic                      wr_en,
  input  logic [CW-1:0]             cnt,
  input  logic [spt_pkg::KEY_W-1:0] addr,
  input  logic [spt_pkg::DATA_W-1:0] data,
  input  spt_pkg::link_t            link_i,
  output spt_pkg::link_t            link_o,
  output logic                      eq_o,
  output logic                      ins_o
);
  import spt_pkg::*;

  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] data_r;
  logic              gt_r;
  logic              eq_r;
  logic              occ;
  logic              at_end;

  // entry is live when below the fill count
  assign occ    = (CW'(IDX) < cnt);
  assign at_end = (CW'(IDX) == cnt);

  // compare flags against the new key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmp_en) begin
      gt_r <= occ && (key_r > addr);
      eq_r <= occ && (key_r == addr);
    end
  end

  // insertion point: first larger entry, or the first free place
  assign ins_o = occ ? (gt_r && !link_i.gt) : (at_end && !link_i.gt);
  assign eq_o  = eq_r;

  // shift up from the lower neighbor or take the new entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (link_i.gt) begin
        key_r  <= link_i.key;
        data_r <= link_i.data;
      end else if (ins_o) begin
        key_r  <= addr;
        data_r <= data;
      end
    end
  end

  assign link_o.gt   = gt_r;
  assign link_o.key  = key_r;
  assign link_o.data = data_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted page tracking table testbench
// Drives insert and clear transactions through the start/busy handshake,
// tracks the sorted key list alongside the block and checks status, slot
// and entry count of every result strobe in order.
// ----------------------------------------------------------------------------
module tb_top;
  import spt_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  // keeps the sorted key list and the results it implies
  class page_table_scoreboard;
    bit [KEY_W-1:0]  key_list[$];
    bit [DATA_W-1:0] data_list[$];
    out_t            expected_q[$];
    int errors;
    int n_insert;
    int n_dup;
    int n_full;
    int n_clear;
    int peak_fill;

    // accepted input transaction: update the table copy, queue the result
    function void note_item(in_t it);
      out_t want;
      int   pos;
      bit   dup;
      want = '0;
      want.status = STATUS_OK;
      if (it.func == FUNC_CLEAR) begin
        key_list.delete();
        data_list.delete();
        n_clear++;
      end else if (key_list.size() >= DEPTH) begin
        // full check wins over the duplicate check
        want.status = STATUS_FULL;
        want.entry_count = CNT_W'(key_list.size());
        n_full++;
      end else begin
        pos = key_list.size();
        dup = 1'b0;
        for (int i = 0; i < key_list.size(); i++) begin
          if (key_list[i] == it.virt_addr) begin
            dup = 1'b1;
            pos = i;
            break;
          end
          if (key_list[i] > it.virt_addr) begin
            pos = i;
            break;
          end
        end
        if (dup) begin
          want.status = STATUS_DUP;
          n_dup++;
        end else begin
          key_list.insert(pos, it.virt_addr);
          data_list.insert(pos, it.entry_data);
          n_insert++;
        end
        want.slot = SLOT_W'(pos);
        want.entry_count = CNT_W'(key_list.size());
      end
      if (key_list.size() > peak_fill) peak_fill = key_list.size();
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // result strobe: compare against the oldest queued expectation
    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d slot=%0d count=%0d",
                         got.status, got.slot, got.entry_count));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.slot !== want.slot)
        report($sformatf("slot got %0d want %0d", got.slot, want.slot));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count got %0d want %0d", got.entry_count,
                         want.entry_count));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  int n_sent;
  int stall_cycles;

  page_table_scoreboard sb;

  sorted_page_tracking_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // present one transaction, optionally after a random gap, and wait for it
  task send_item(input in_t it, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
    n_sent++;
  endtask

  task send_insert(input bit [KEY_W-1:0] addr, input bit [DATA_W-1:0] data,
                   input int idle_pct);
    in_t it;
    it = '0;
    it.func       = FUNC_INSERT;
    it.virt_addr  = addr;
    it.entry_data = data;
    send_item(it, idle_pct);
  endtask

  // clear carries random ignored fields so their bits toggle too
  task send_clear(input bit [KEY_W-1:0] addr, input int idle_pct);
    in_t it;
    it = '0;
    it.func       = FUNC_CLEAR;
    it.virt_addr  = addr;
    it.entry_data = $urandom;
    send_item(it, idle_pct);
  endtask

  // address source; sometimes reuses a stored key to force duplicates
  function bit [KEY_W-1:0] pick_addr(input int mode);
    if (sb.key_list.size() > 0 && $urandom_range(0, 9) == 0)
      return sb.key_list[$urandom_range(0, sb.key_list.size() - 1)];
    case (mode)
      0:       return $urandom;
      1:       return KEY_W'($urandom_range(0, 127));
      2:       return 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 127));
      default: return $urandom & 32'hF000_000F;
    endcase
  endfunction

  // random sequences, starting from a cleared table: short runs and fill-to-full runs
  task run_phase(input int idle_pct, input int quota);
    int  base;
    int  len;
    int  mode;
    bit  fill_run;
    bit  first;
    base  = n_sent;
    first = 1'b1;
    while (n_sent - base < quota) begin
      if (first || $urandom_range(0, 4) != 0) send_clear($urandom, idle_pct);
      fill_run = first || $urandom_range(0, 3) == 0;
      if (fill_run) begin
        len  = $urandom_range(80, 92);
        mode = 0;
      end else begin
        len  = $urandom_range(1, 24);
        mode = $urandom_range(0, 3);
      end
      repeat (len) begin
        if (!fill_run && $urandom_range(0, 39) == 0)
          send_clear($urandom, idle_pct);
        else
          send_insert(pick_addr(mode), $urandom, idle_pct);
      end
      first = 1'b0;
    end
  endtask

  initial begin
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ends of the key range, front, middle and past-end inserts,
    // duplicates at first, last and inner slots, clear on a partly filled and on an empty table
    send_insert(32'h0000_1000, 32'h0000_0000, 0);
    send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_insert(32'h0000_0000, 32'h0000_0000, 0);
    send_insert(32'h8000_0000, 32'h1234_5678, 0);
    send_insert(32'h0000_1000, 32'hFFFF_FFFF, 0);
    send_insert(32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_insert(32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_insert(32'h7FFF_FFFF, 32'hA5A5_A5A5, 0);
    send_insert(32'h8000_0001, 32'h5A5A_5A5A, 0);
    send_clear(32'hFFFF_FFFF, 0);
    send_insert(32'h5555_AAAA, 32'hAAAA_5555, 0);
    send_insert(32'hAAAA_5555, 32'h5555_AAAA, 0);
    send_insert(32'h5555_AAAA, 32'h0000_0000, 0);
    send_clear(32'h0000_0000, 0);
    send_clear(32'h0000_0000, 0);
    send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

    // random phases; the receiver cannot stall, so its phase runs flat out
    run_phase(0, 450);
    run_phase(47, 450);
    run_phase(0, 450);
    run_phase(18, 450);
    start <= 1'b0;

    // drain, then give late strobes a chance to show up
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d transactions: %0d inserts, %0d duplicates,",
             n_sent, sb.n_insert, sb.n_dup);
    $display("  %0d full rejects, %0d clears; largest fill level %0d of %0d",
             sb.n_full, sb.n_clear, sb.peak_fill, DEPTH);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
